### sv/mbet_pkg.sv
package mbet_pkg;

   localparam int MAX_ITERATIONS_DEF = 256;
   localparam int IMAGE_WIDTH_DEF    = 1024;
   localparam int IMAGE_HEIGHT_DEF   = 768;

   localparam int PIX_W       = 10;
   localparam int OFF_W       = 13;
   localparam int STEP_W      = 31;
   localparam int Q_W         = 32;
   localparam int PROD_W      = 64;
   localparam int FRAC_BITS   = 28;
   localparam int ITER_OUT_W  = 9;
   localparam int SMOOTH_W    = 25;
   localparam int SMOOTH_FRAC = 16;
   localparam int SMOOTH_CALC_W = 34;
   localparam int CSR_INDEX_W = 2;

   localparam int RADICAND_W  = 64;
   localparam int ROOT_W      = 32;
   localparam int ROOT_CNT_W  = $clog2(ROOT_W);
   localparam int REM_W       = ROOT_W + 3;

   localparam int RECIP_W       = 16;
   localparam int RECIP_CNT_W   = $clog2(RECIP_W);
   localparam int RECIP_NUM_EXP = 44;
   localparam int DIVIDEND_W    = RECIP_NUM_EXP + 1;
   localparam int DIVISOR_W     = ROOT_W + RECIP_W - 1;

   localparam logic [STEP_W-1:0]   STEP_RESET = STEP_W'(1048576);
   localparam logic [PROD_W-1:0]   ESCAPE_SQ  = PROD_W'(4) << (2 * FRAC_BITS);
   localparam logic [SMOOTH_CALC_W-1:0] SMOOTH_MAX = SMOOTH_CALC_W'((1 << SMOOTH_W) - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_REAL = 2'd0,
      CSR_STEP_IMAG = 2'd1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_C_RE,
      ST_C_IM,
      ST_C_SAT,
      ST_MUL_RR,
      ST_MUL_II,
      ST_MUL_RI,
      ST_UPDATE,
      ST_ROOT,
      ST_RECIP,
      ST_FINISH
   } state_type;

   function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
      logic [PROD_W-Q_W:0] hi;
      logic signed [Q_W-1:0] r;
      hi = v[PROD_W-1:Q_W-1];
      if ((hi == '0) || (hi == '1)) begin
         r = v[Q_W-1:0];
      end else if (v[PROD_W-1]) begin
         r = {1'b1, {(Q_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(Q_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

### sv/mandelbrot_escape_time_pixel.sv
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_pixel_x, req_pixel_y
// rsp      out        rsp_valid/rsp_stall   rsp_out_x, rsp_out_y, rsp_inside_set,
//                                           rsp_iter_count, rsp_smooth_value
// csr      in         csr_write             csr_index, csr_data
//
// one 32x32 multiplier is shared: c in C_RE/C_IM, then MUL_RR/MUL_II/MUL_RI per iteration n
// escaped pixel: then square root, then reciprocal; inside pixel: ends at n = MAX_ITERATIONS
// one pixel in flight; req_stall is high from accept until the result enters the rsp register
// a new pixel is taken while the previous result waits under rsp_stall
// synchronous reset clears the sequencer and rsp_valid and loads STEP_RESET into the step registers
module mandelbrot_escape_time_pixel #(
   parameter int MAX_ITERATIONS = mbet_pkg::MAX_ITERATIONS_DEF,
   parameter int IMAGE_WIDTH    = mbet_pkg::IMAGE_WIDTH_DEF,
   parameter int IMAGE_HEIGHT   = mbet_pkg::IMAGE_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mbet_pkg::PIX_W-1:0]           req_pixel_x,
   input  logic [mbet_pkg::PIX_W-1:0]           req_pixel_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbet_pkg::PIX_W-1:0]           rsp_out_x,
   output logic [mbet_pkg::PIX_W-1:0]           rsp_out_y,
   output logic                                 rsp_inside_set,
   output logic [mbet_pkg::ITER_OUT_W-1:0]      rsp_iter_count,
   output logic [mbet_pkg::SMOOTH_W-1:0]        rsp_smooth_value,
   input  logic                                 csr_write,
   input  logic [mbet_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mbet_pkg::STEP_W-1:0]          csr_data
);
   import mbet_pkg::*;

   localparam int HALF_W = IMAGE_WIDTH / 2;
   localparam int HALF_H = IMAGE_HEIGHT / 2;
   localparam int IW     = $clog2(MAX_ITERATIONS + 1);
   localparam int CW     = (IW > ITER_OUT_W) ? IW : ITER_OUT_W;

   state_type state_ff, state_in;

   logic [STEP_W-1:0]         step_re_ff, step_re_in;
   logic [STEP_W-1:0]         step_im_ff, step_im_in;
   logic [PIX_W-1:0]          px_ff, px_in;
   logic [PIX_W-1:0]          py_ff, py_in;
   logic signed [Q_W-1:0]     c_re_ff, c_re_in;
   logic signed [Q_W-1:0]     c_im_ff, c_im_in;
   logic signed [Q_W-1:0]     z_re_ff, z_re_in;
   logic signed [Q_W-1:0]     z_im_ff, z_im_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [PROD_W-1:0]  rr_ff, rr_in;
   logic signed [PROD_W-1:0]  diff_ff, diff_in;
   logic [PROD_W-1:0]         mag_ff, mag_in;
   logic [IW-1:0]             n_ff, n_in;
   logic                      inside_ff, inside_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]          rsp_x_ff, rsp_x_in;
   logic [PIX_W-1:0]          rsp_y_ff, rsp_y_in;
   logic                      rsp_inside_ff, rsp_inside_in;
   logic [ITER_OUT_W-1:0]     rsp_iter_ff, rsp_iter_in;
   logic [SMOOTH_W-1:0]       rsp_smooth_ff, rsp_smooth_in;

   logic signed [Q_W-1:0]     mul_a, mul_b;
   logic signed [OFF_W-1:0]   off_x, off_y;
   logic signed [PROD_W-1:0]  re_sum, im_sum;
   logic [IW-1:0]             n_inc;
   logic [CW-1:0]             n_wide;
   logic [SMOOTH_CALC_W-1:0]  smooth_full;
   logic                      out_free;

   logic                      sqrt_start, sqrt_done;
   logic [ROOT_W-1:0]         sqrt_root;
   logic                      recip_start, recip_done;
   logic [RECIP_W-1:0]        recip_q;

   mbet_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (mag_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   mbet_recip u_recip (
      .clock    (clock),
      .reset    (reset),
      .start    (recip_start),
      .divisor  (sqrt_root),
      .done     (recip_done),
      .quotient (recip_q)
   );

   assign off_x = signed'({{(OFF_W-PIX_W){1'b0}}, px_ff}) - OFF_W'(HALF_W);
   assign off_y = signed'({{(OFF_W-PIX_W){1'b0}}, py_ff}) - OFF_W'(HALF_H);

   // shared multiplier operands
   always_comb begin
      unique case (state_ff)
         ST_C_RE: begin
            mul_a = {{(Q_W-OFF_W){off_x[OFF_W-1]}}, off_x};
            mul_b = signed'({1'b0, step_re_ff});
         end
         ST_C_IM: begin
            mul_a = {{(Q_W-OFF_W){off_y[OFF_W-1]}}, off_y};
            mul_b = signed'({1'b0, step_im_ff});
         end
         ST_MUL_RR: begin
            mul_a = z_re_ff;
            mul_b = z_re_ff;
         end
         ST_MUL_II: begin
            mul_a = z_im_ff;
            mul_b = z_im_ff;
         end
         default: begin
            mul_a = z_re_ff;
            mul_b = z_im_ff;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign re_sum      = (diff_ff >>> FRAC_BITS) + PROD_W'(c_re_ff);
   assign im_sum      = (prod_ff >>> (FRAC_BITS - 1)) + PROD_W'(c_im_ff);
   assign n_inc       = n_ff + IW'(1);
   assign n_wide      = CW'(n_ff);
   assign smooth_full = ((SMOOTH_CALC_W'(n_ff) + SMOOTH_CALC_W'(1)) << SMOOTH_FRAC)
                        - SMOOTH_CALC_W'(recip_q);
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      step_re_in    = step_re_ff;
      step_im_in    = step_im_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      c_re_in       = c_re_ff;
      c_im_in       = c_im_ff;
      z_re_in       = z_re_ff;
      z_im_in       = z_im_ff;
      rr_in         = rr_ff;
      diff_in       = diff_ff;
      mag_in        = mag_ff;
      n_in          = n_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_iter_in   = rsp_iter_ff;
      rsp_smooth_in = rsp_smooth_ff;
      sqrt_start    = 1'b0;
      recip_start   = 1'b0;
      req_stall     = (state_ff != ST_IDLE);

      if (csr_write) begin
         if (csr_index == CSR_STEP_REAL) begin
            step_re_in = csr_data;
         end else if (csr_index == CSR_STEP_IMAG) begin
            step_im_in = csr_data;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in     = req_pixel_x;
               py_in     = req_pixel_y;
               n_in      = '0;
               inside_in = 1'b0;
               state_in  = ST_C_RE;
            end
         end
         ST_C_RE: begin
            state_in = ST_C_IM;
         end
         ST_C_IM: begin
            c_re_in  = sat_q(prod_ff);
            z_re_in  = '0;
            z_im_in  = '0;
            state_in = ST_C_SAT;
         end
         ST_C_SAT: begin
            c_im_in  = sat_q(prod_ff);
            state_in = ST_MUL_RR;
         end
         ST_MUL_RR: begin
            state_in = ST_MUL_II;
         end
         ST_MUL_II: begin
            rr_in    = prod_ff;
            state_in = ST_MUL_RI;
         end
         ST_MUL_RI: begin
            mag_in   = unsigned'(rr_ff) + unsigned'(prod_ff);
            diff_in  = rr_ff - prod_ff;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (mag_ff >= ESCAPE_SQ) begin
               sqrt_start = 1'b1;
               state_in   = ST_ROOT;
            end else begin
               n_in = n_inc;
               if (n_inc == IW'(MAX_ITERATIONS)) begin
                  inside_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  z_re_in  = sat_q(re_sum);
                  z_im_in  = sat_q(im_sum);
                  state_in = ST_MUL_RR;
               end
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               recip_start = 1'b1;
               state_in    = ST_RECIP;
            end
         end
         ST_RECIP: begin
            if (recip_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = px_ff;
               rsp_y_in      = py_ff;
               rsp_inside_in = inside_ff;
               rsp_iter_in   = n_wide[ITER_OUT_W-1:0];
               if (inside_ff) begin
                  rsp_smooth_in = '0;
               end else if (smooth_full > SMOOTH_MAX) begin
                  rsp_smooth_in = SMOOTH_MAX[SMOOTH_W-1:0];
               end else begin
                  rsp_smooth_in = smooth_full[SMOOTH_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         step_re_ff   <= STEP_RESET;
         step_im_ff   <= STEP_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_re_ff   <= step_re_in;
         step_im_ff   <= step_im_in;
      end
      px_ff         <= px_in;
      py_ff         <= py_in;
      c_re_ff       <= c_re_in;
      c_im_ff       <= c_im_in;
      z_re_ff       <= z_re_in;
      z_im_ff       <= z_im_in;
      prod_ff       <= prod_in;
      rr_ff         <= rr_in;
      diff_ff       <= diff_in;
      mag_ff        <= mag_in;
      n_ff          <= n_in;
      inside_ff     <= inside_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_iter_ff   <= rsp_iter_in;
      rsp_smooth_ff <= rsp_smooth_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_inside_set   = rsp_inside_ff;
   assign rsp_iter_count   = rsp_iter_ff;
   assign rsp_smooth_value = rsp_smooth_ff;

endmodule

### sv/mbet_sqrt.sv
module mbet_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [mbet_pkg::RADICAND_W-1:0]    radicand,
   output logic                               done,
   output logic [mbet_pkg::ROOT_W-1:0]        root
);
   import mbet_pkg::*;

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [ROOT_CNT_W-1:0]  count_ff, count_in;
   logic [RADICAND_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [ROOT_W-1:0]      root_ff, root_in;
   logic [REM_W-1:0]       rem_sh;
   logic [REM_W-1:0]       trial;

   // one root bit per cycle, two radicand bits brought down
   always_comb begin
      rem_sh   = {rem_ff[REM_W-3:0], rad_ff[RADICAND_W-1 -: 2]};
      trial    = REM_W'({root_ff, 2'b01});
      busy_in  = busy_ff;
      count_in = count_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '1;
         rad_in   = radicand;
         rem_in   = '0;
         root_in  = '0;
      end else if (busy_ff) begin
         rad_in = rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         count_in = count_ff - ROOT_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

### sv/mbet_recip.sv
module mbet_recip (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [mbet_pkg::ROOT_W-1:0]    divisor,
   output logic                           done,
   output logic [mbet_pkg::RECIP_W-1:0]   quotient
);
   import mbet_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [RECIP_CNT_W-1:0]  count_ff, count_in;
   logic [DIVIDEND_W-1:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0]    div_ff, div_in;
   logic [RECIP_W-1:0]      q_ff, q_in;
   logic                    ge;

   // restoring division of 2^44, one quotient bit per cycle
   always_comb begin
      ge       = DIVISOR_W'(rem_ff) >= div_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '1;
         rem_in   = DIVIDEND_W'(1) << RECIP_NUM_EXP;
         div_in   = {divisor, {(RECIP_W-1){1'b0}}};
         q_in     = '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - div_ff[DIVIDEND_W-1:0];
         end
         q_in     = {q_ff[RECIP_W-2:0], ge};
         div_in   = div_ff >> 1;
         count_in = count_ff - RECIP_CNT_W'(1);
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      q_ff     <= q_in;
   end

   assign done     = done_ff;
   assign quotient = q_ff;

endmodule

### tb/sv/tb_top.sv
module tb_top;

   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int PHASE_PIXELS = 320;
   localparam int PIX_W = mbet_pkg::PIX_W;
   localparam int STEP_W = mbet_pkg::STEP_W;
   localparam logic [mbet_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [mbet_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;
   localparam logic [mbet_pkg::STEP_W-1:0] STEP_DEFAULT = 31'd1048576;
   localparam logic [mbet_pkg::STEP_W-1:0] STEP_TOP = 31'h7FFF_FFFF;

   typedef struct packed {
      logic [mbet_pkg::PIX_W-1:0]      x;
      logic [mbet_pkg::PIX_W-1:0]      y;
      logic                            in_set;
      logic [mbet_pkg::ITER_OUT_W-1:0] count;
      logic [mbet_pkg::SMOOTH_W-1:0]   smooth;
   } escape_result_type;

   class escape_tracker;
      localparam longint HALF_W = mbet_pkg::IMAGE_WIDTH_DEF / 2;
      localparam longint HALF_H = mbet_pkg::IMAGE_HEIGHT_DEF / 2;
      localparam int unsigned ITER_LIMIT = mbet_pkg::MAX_ITERATIONS_DEF;
      localparam longint unsigned ESCAPE_LIMIT = 64'd4 << 56;
      localparam longint unsigned SMOOTH_LIMIT = 64'h1FF_FFFF;
      localparam longint Q_HI = 64'sd2147483647;
      localparam longint Q_LO = -64'sd2147483648;

      logic [mbet_pkg::STEP_W-1:0] step_re;
      logic [mbet_pkg::STEP_W-1:0] step_im;
      escape_result_type expected_escapes[$];
      int mismatches;

      function new();
         step_re = STEP_DEFAULT;
         step_im = STEP_DEFAULT;
         mismatches = 0;
      endfunction

      function void write_reg(logic [mbet_pkg::CSR_INDEX_W-1:0] index,
                              logic [mbet_pkg::STEP_W-1:0] value);
         case (index)
            mbet_pkg::CSR_STEP_REAL: begin
               step_re = value;
            end
            mbet_pkg::CSR_STEP_IMAG: begin
               step_im = value;
            end
            default: begin
            end
         endcase
      endfunction

      function longint clamp_q(longint v);
         if (v > Q_HI) begin
            return Q_HI;
         end
         if (v < Q_LO) begin
            return Q_LO;
         end
         return v;
      endfunction

      function longint unsigned modulus_sq(longint re, longint im);
         return longint'(re * re) + longint'(im * im);
      endfunction

      function escape_result_type escape_time(logic [mbet_pkg::PIX_W-1:0] px,
                                              logic [mbet_pkg::PIX_W-1:0] py);
         longint c_re, c_im, z_re, z_im, nre;
         longint unsigned mag, root, trial, recip, smooth;
         int unsigned n;
         bit done;
         escape_result_type r;
         c_re = clamp_q((longint'(px) - HALF_W) * longint'(step_re));
         c_im = clamp_q((longint'(py) - HALF_H) * longint'(step_im));
         z_re = 0;
         z_im = 0;
         n = 0;
         done = 0;
         mag = 0;
         while (!done) begin
            mag = modulus_sq(z_re, z_im);
            if (mag >= ESCAPE_LIMIT) begin
               done = 1;
            end else begin
               n++;
               if (n >= ITER_LIMIT) begin
                  done = 1;
               end else begin
                  nre = clamp_q(((z_re * z_re - z_im * z_im) >>> 28) + c_re);
                  z_im = clamp_q(((z_re * z_im) >>> 27) + c_im);
                  z_re = nre;
               end
            end
         end
         r.x = px;
         r.y = py;
         r.in_set = (n == ITER_LIMIT);
         r.count = n[mbet_pkg::ITER_OUT_W-1:0];
         smooth = 0;
         if (!r.in_set) begin
            root = 0;
            for (int b = 31; b >= 0; b--) begin
               trial = root | (64'd1 << b);
               if (trial * trial <= mag) begin
                  root = trial;
               end
            end
            recip = (root != 0) ? (64'd1 << 44) / root : 64'd0;
            smooth = ((longint'(n) + 1) << 16) - recip;
            if (smooth > SMOOTH_LIMIT) begin
               smooth = SMOOTH_LIMIT;
            end
         end
         r.smooth = smooth[mbet_pkg::SMOOTH_W-1:0];
         return r;
      endfunction

      function void note_pixel(logic [mbet_pkg::PIX_W-1:0] px,
                               logic [mbet_pkg::PIX_W-1:0] py);
         expected_escapes.push_back(escape_time(px, py));
      endfunction

      function int pending();
         return expected_escapes.size();
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task compare(string field, longint got, longint want, escape_result_type e);
         if (got != want) begin
            report($sformatf("pixel (%0d,%0d) %s: got %0d, expected %0d",
                             e.x, e.y, field, got, want));
         end
      endtask

      task check_result(escape_result_type got);
         escape_result_type want;
         if (expected_escapes.size() == 0) begin
            report($sformatf("result beat for pixel (%0d,%0d) with none pending",
                             got.x, got.y));
            return;
         end
         want = expected_escapes.pop_front();
         compare("out_x", got.x, want.x, want);
         compare("out_y", got.y, want.y, want);
         compare("inside_set", got.in_set, want.in_set, want);
         compare("iter_count", got.count, want.count, want);
         compare("smooth_value", got.smooth, want.smooth, want);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic [mbet_pkg::PIX_W-1:0] req_pixel_x;
   logic [mbet_pkg::PIX_W-1:0] req_pixel_y;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [mbet_pkg::PIX_W-1:0] rsp_out_x;
   logic [mbet_pkg::PIX_W-1:0] rsp_out_y;
   logic rsp_inside_set;
   logic [mbet_pkg::ITER_OUT_W-1:0] rsp_iter_count;
   logic [mbet_pkg::SMOOTH_W-1:0] rsp_smooth_value;
   logic csr_write;
   logic [mbet_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [mbet_pkg::STEP_W-1:0] csr_data;

   escape_tracker tracker = new();
   escape_result_type seen;
   int cycle_count = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int idle_pct = 0;

   mandelbrot_escape_time_pixel uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_x(req_pixel_x),
      .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y),
      .rsp_inside_set(rsp_inside_set),
      .rsp_iter_count(rsp_iter_count),
      .rsp_smooth_value(rsp_smooth_value),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(10, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.x = rsp_out_x;
            seen.y = rsp_out_y;
            seen.in_set = rsp_inside_set;
            seen.count = rsp_iter_count;
            seen.smooth = rsp_smooth_value;
            tracker.check_result(seen);
         end
         if (req_valid && !req_stall) begin
            tracker.note_pixel(req_pixel_x, req_pixel_y);
         end
      end
   end

   task automatic send_pixel(logic [mbet_pkg::PIX_W-1:0] x, logic [mbet_pkg::PIX_W-1:0] y);
      int gap;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         gap = $urandom_range(11, 1);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic settle();
      release_req();
      wait_drained();
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [mbet_pkg::CSR_INDEX_W-1:0] index,
                            logic [mbet_pkg::STEP_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      tracker.write_reg(index, value);
   endtask

   task automatic set_steps(logic [mbet_pkg::STEP_W-1:0] re, logic [mbet_pkg::STEP_W-1:0] im);
      write_csr(mbet_pkg::CSR_STEP_REAL, re);
      write_csr(mbet_pkg::CSR_STEP_IMAG, im);
   endtask

   initial begin
      logic [mbet_pkg::STEP_W-1:0] re_step, im_step;
      logic [mbet_pkg::PIX_W-1:0] px, py;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_write = 1'b0;
      csr_index = mbet_pkg::CSR_STEP_REAL;
      csr_data = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset steps: full view of the set
      idle_pct = 20;
      stall_pct = 20;
      send_pixel(10'd512, 10'd384);
      send_pixel(10'd0, 10'd384);
      send_pixel(10'd1023, 10'd384);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd0, 10'd1023);
      send_pixel(10'd1023, 10'd0);
      send_pixel(10'd512, 10'd0);
      send_pixel(10'd768, 10'd384);
      send_pixel(10'd447, 10'd384);
      send_pixel(10'd321, 10'd384);
      send_pixel(10'd100, 10'd800);
      send_pixel(10'd600, 10'd500);

      // largest steps: c saturates except near the centre
      settle();
      set_steps(STEP_TOP, STEP_TOP);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd513, 10'd385);
      send_pixel(10'd514, 10'd386);
      send_pixel(10'd511, 10'd383);
      send_pixel(10'd510, 10'd382);
      send_pixel(10'd512, 10'd384);

      // zero steps: every pixel maps to the origin
      settle();
      set_steps('0, '0);
      send_pixel(10'd0, 10'd0);
      send_pixel(10'd1023, 10'd1023);
      send_pixel(10'd300, 10'd700);

      settle();
      set_steps(STEP_TOP, 31'd1);
      send_pixel(10'd512, 10'd0);
      send_pixel(10'd1023, 10'd767);

      for (int p = 0; p < 6; p++) begin
         settle();
         case (p)
            0: begin
               re_step = STEP_DEFAULT;
               im_step = STEP_DEFAULT;
               idle_pct = 20;
               stall_pct = 20;
            end
            1: begin
               re_step = STEP_W'($urandom_range(32'h20_0000, 32'h8_0000));
               im_step = STEP_W'($urandom_range(32'h20_0000, 32'h8_0000));
               idle_pct = 0;
               stall_pct = 30;
            end
            2: begin
               re_step = STEP_W'($urandom_range(32'h40_0000, 32'h4_0000));
               im_step = STEP_W'($urandom_range(32'h40_0000, 32'h4_0000));
               idle_pct = 30;
               stall_pct = 0;
            end
            3: begin
               re_step = STEP_W'($urandom);
               im_step = STEP_W'($urandom);
               idle_pct = 10;
               stall_pct = 10;
               write_csr(CSR_SPARE_LO, STEP_W'($urandom));
               write_csr(CSR_SPARE_HI, STEP_W'($urandom));
            end
            4: begin
               re_step = STEP_W'($urandom_range(32'h10_0000, 32'h1_0000));
               im_step = STEP_W'($urandom_range(32'h10_0000, 32'h1_0000));
               idle_pct = 25;
               stall_pct = 25;
            end
            default: begin
               re_step = STEP_DEFAULT;
               im_step = STEP_DEFAULT;
               idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         set_steps(re_step, im_step);
         for (int i = 0; i < PHASE_PIXELS; i++) begin
            if (p != 5 && $urandom_range(63) == 0) begin
               release_req();
               wait_drained();
            end
            px = PIX_W'($urandom_range(1023));
            py = PIX_W'(($urandom_range(7) == 0) ? $urandom_range(1023, 768)
                                                 : $urandom_range(767));
            send_pixel(px, py);
         end
      end

      release_req();
      wait_drained();
      repeat (64) @(posedge clock);
      if (tracker.pending() != 0) begin
         tracker.report($sformatf("%0d results never arrived", tracker.pending()));
      end
      if (tracker.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
